[rtl/psl_pkg.sv]
package psl_pkg;

  // Store geometry
  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int OCNT_W   = 6;
  // compare width, wide enough for position, count + 1 and the output count
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [2:0] {
    ACT_INSERT_AT    = 3'd0,
    ACT_DELETE_AT    = 3'd1,
    ACT_INSERT_FRONT = 3'd2,
    ACT_INSERT_BACK  = 3'd3,
    ACT_DELETE_FRONT = 3'd4,
    ACT_DELETE_BACK  = 3'd5,
    ACT_DUMP         = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // What every cell does at each clock edge
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,   // cells past idx take left neighbor, idx takes val
    CELL_DEL  = 2'd2,   // cells from idx on take right neighbor
    CELL_ROT  = 2'd3    // cells below idx take right neighbor, idx takes val
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] val;
  } cell_ctl_t;

endpackage

[rtl/psl_cell.sv]
module psl_cell (
  input  logic                         clk,
  input  psl_pkg::cell_ctl_t           ctl,
  input  logic [psl_pkg::IDX_W-1:0]    index,
  input  logic signed [31:0]           left,
  input  logic signed [31:0]           right,
  output logic signed [31:0]           data
);
  import psl_pkg::*;

  // one slot of the sequence; shifts with its neighbors
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_HOLD: begin
        data <= data;
      end
      CELL_INS: begin
        if (index > ctl.idx) begin
          data <= left;
        end else if (index == ctl.idx) begin
          data <= ctl.val;
        end
      end
      CELL_DEL: begin
        if (index >= ctl.idx) begin
          data <= right;
        end
      end
      CELL_ROT: begin
        if (index < ctl.idx) begin
          data <= right;
        end else if (index == ctl.idx) begin
          data <= ctl.val;
        end
      end
    endcase
  end

endmodule

[rtl/positional_sequence_list_core.sv]
// Positional sequence list: an ordered row of up to CAPACITY signed 32-bit
// values held in a chain of cells, one value per cell.
//
// Command channel: a transaction is taken at a clock edge with start high
// and busy low. It carries action, value and position.
// Result channel: each result sits on status/count/element/is_last for one
// cycle with done high. The receiver cannot stall; it must take every result.
//
// The first (or only) result is registered and appears in the cycle after the command.
// Insert and delete actions shift the whole chain in parallel and leave
// busy low, so a new command may follow in the next cycle.
// Dump rotates the chain one cell per cycle, reading the front cell, and
// gives count results on consecutive cycles; busy stays high while the rest
// are read out, so no command is taken mid-dump (one result on an empty list).
//
// Reset clears the element count and the sequencer; cell contents are
// undefined until written and only slots below the count are ever read.
module positional_sequence_list_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    action,
  input  logic signed [31:0]            value,
  input  logic [psl_pkg::POS_W-1:0]     position,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [psl_pkg::OCNT_W-1:0]    count,
  output logic signed [31:0]            element,
  output logic                          is_last
);
  import psl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [CNT_W-1:0]   dump_k, dump_k_next;
  cell_ctl_t          ctl;
  logic signed [31:0] cell_data [CAPACITY];

  logic               accept;
  logic [CMP_W-1:0]   posx, cntx;
  logic [IDX_W-1:0]   pos_idx, last_idx;
  logic [CNT_W-1:0]   k_cur;
  logic               dump_emit, dump_last;
  logic               res_we;
  status_t            res_status;

  assign busy     = (state == S_DUMP);
  assign accept   = start && !busy;
  assign posx     = CMP_W'(position);
  assign cntx     = CMP_W'(cnt);
  assign pos_idx  = IDX_W'(position - POS_W'(1));
  assign last_idx = IDX_W'(cnt - CNT_W'(1));

  // dump step: emit front cell, rotate the occupied part of the chain
  assign k_cur     = busy ? dump_k : '0;
  assign dump_emit = busy || (accept && action == ACT_DUMP && cnt != '0);
  assign dump_last = (k_cur == cnt - CNT_W'(1));

  // command decode and chain control
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    dump_k_next = dump_k;
    ctl.op      = CELL_HOLD;
    ctl.idx     = pos_idx;
    ctl.val     = value;
    res_we      = 1'b0;
    res_status  = ST_OK;
    if (dump_emit) begin
      ctl.op      = CELL_ROT;
      ctl.idx     = last_idx;
      ctl.val     = cell_data[0];
      dump_k_next = k_cur + CNT_W'(1);
      state_next  = dump_last ? S_IDLE : S_DUMP;
    end else if (accept) begin
      res_we = 1'b1;
      unique case (action)
        ACT_INSERT_AT: begin
          if (position == '0 || posx > cntx + CMP_W'(1)) begin
            res_status = ST_BADPOS;
          end else if (cnt == CNT_W'(CAPACITY)) begin
            res_status = ST_FULL;
          end else begin
            ctl.op   = CELL_INS;
            cnt_next = cnt + CNT_W'(1);
          end
        end
        ACT_DELETE_AT: begin
          if (position == '0 || posx > cntx) begin
            res_status = ST_BADPOS;
          end else begin
            ctl.op   = CELL_DEL;
            cnt_next = cnt - CNT_W'(1);
          end
        end
        ACT_INSERT_FRONT, ACT_INSERT_BACK: begin
          if (cnt == CNT_W'(CAPACITY)) begin
            res_status = ST_FULL;
          end else begin
            ctl.op   = CELL_INS;
            ctl.idx  = (action == ACT_INSERT_FRONT) ? '0 : IDX_W'(cnt);
            cnt_next = cnt + CNT_W'(1);
          end
        end
        ACT_DELETE_FRONT, ACT_DELETE_BACK: begin
          if (cnt == '0) begin
            res_status = ST_EMPTY;
          end else begin
            ctl.op   = CELL_DEL;
            ctl.idx  = (action == ACT_DELETE_FRONT) ? '0 : last_idx;
            cnt_next = cnt - CNT_W'(1);
          end
        end
        ACT_DUMP: begin
          // only reached on an empty list
          res_status = ST_EMPTY;
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      dump_k <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      dump_k <= dump_k_next;
      done   <= dump_emit || res_we;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (dump_emit) begin
      status  <= ST_OK;
      count   <= cntx[OCNT_W-1:0];
      element <= cell_data[0];
      is_last <= dump_last;
    end else if (res_we) begin
      status  <= res_status;
      count   <= OCNT_W'(cnt_next);
      element <= '0;
      is_last <= 1'b1;
    end
  end

  // chain of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] left_in, right_in;
    if (g == 0) begin : g_first
      assign left_in = cell_data[g];
    end else begin : g_mid
      assign left_in = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_in = cell_data[g];
    end else begin : g_body
      assign right_in = cell_data[g+1];
    end
    psl_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .index (IDX_W'(g)),
      .left  (left_in),
      .right (right_in),
      .data  (cell_data[g])
    );
  end

  // every accepted command gives a result in the next cycle
  a_cmd_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted command produced no result");

  // a non-final result only comes out of a running dump
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    (done && !is_last) |-> busy)
    else $error("non-final result with no dump in progress");

  // while dumping, a result comes out every cycle
  a_dump_stream: assert property (@(posedge clk) disable iff (rst)
    busy |-> done)
    else $error("dump stalled");

  // count never passes capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("element count beyond capacity");

endmodule
